### rtl/rtcm_pkg.sv
// ----------------------------------------------------------------------------
// rtcm_pkg: shared types, constants and functions of the NCO complex mixer
// Widths, register codes, the queued item layout, the quarter-wave sine
// table builder and the Q15 rounding with saturation.
// ----------------------------------------------------------------------------
package rtcm_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int TABLE_ADDR_BITS = 10;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // Q1.15 trig values: magnitude table is unsigned, signed value one bit wider
  localparam int FRAC_BITS     = 15;
  localparam int QSIN_BITS     = FRAC_BITS;
  localparam int TRIG_BITS     = FRAC_BITS + 1;
  localparam int QUARTER_N     = 1 << TABLE_ADDR_BITS;
  localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
  localparam int PROD_BITS     = SAMPLE_BITS + TRIG_BITS;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_START_PHASE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    quad_t                         quad;
    logic [TABLE_ADDR_BITS-1:0]    idx;
    logic [PHASE_BITS-1:0]         phase_after;
  } item_t;

  typedef logic [QSIN_BITS-1:0] qsin_rom_t [0:QUARTER_N];

  // sin(pi/2 * j / QUARTER_N) in Q15, Taylor series to x^9 evaluated in Q30
  function automatic logic [QSIN_BITS-1:0] quarter_sin(int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x5;
    logic [63:0] x7;
    logic [63:0] x9;
    longint      v;
    longint      q;
    x  = 64'(j) << (30 - TABLE_ADDR_BITS);
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x5 = (x3 * x2) >> 30;
    x7 = (x5 * x2) >> 30;
    x9 = (x7 * x2) >> 30;
    v = longint'((64'd1686629713 * x) >> 30)
      - longint'((64'd693598668 * x3) >> 30)
      + longint'((64'd85569306 * x5) >> 30)
      - longint'((64'd5026995 * x7) >> 30)
      + longint'((64'd172271 * x9) >> 30);
    if (v < 0) begin
      v = 0;
    end
    q = (v + 16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return q[QSIN_BITS-1:0];
  endfunction

  function automatic qsin_rom_t build_qsin();
    qsin_rom_t rom;
    for (int j = 0; j <= QUARTER_N; j++) begin
      rom[j] = quarter_sin(j);
    end
    return rom;
  endfunction

  // Add half an LSB, floor-shift by the fraction bits, clamp to sample range
  function automatic logic [SAMPLE_BITS-1:0] round_sat(logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS:0]           r;
    logic [PROD_BITS-FRAC_BITS:0]        q;
    logic [PROD_BITS-FRAC_BITS-SAMPLE_BITS+1:0] top;
    r   = {p[PROD_BITS-1], p} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
    q   = r[PROD_BITS:FRAC_BITS];
    top = q[PROD_BITS-FRAC_BITS:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return q[SAMPLE_BITS-1:0];
    end else if (q[PROD_BITS-FRAC_BITS]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/rtcm_front.sv
// ----------------------------------------------------------------------------
// rtcm_front: configuration registers and phase accumulator
// Accepts items, assigns each its phase and pushes it into the queue with
// its quadrant, table index and stepped phase.
// ----------------------------------------------------------------------------
module rtcm_front (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [rtcm_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [rtcm_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [rtcm_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                                      last,
  input  logic                                      q_full,
  output logic                                      push,
  output rtcm_pkg::item_t                           push_item
);

  logic [rtcm_pkg::PHASE_BITS-1:0] phase_step;
  logic [rtcm_pkg::PHASE_BITS-1:0] start_phase;
  logic [rtcm_pkg::PHASE_BITS-1:0] phase_acc;
  logic                            vector_start;
  logic [rtcm_pkg::PHASE_BITS-1:0] phase;
  logic [rtcm_pkg::PHASE_BITS-1:0] phase_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  assign phase      = vector_start ? start_phase : phase_acc;
  assign phase_next = phase + phase_step;

  always_comb begin
    push_item.sample      = sample;
    push_item.last        = last;
    push_item.quad        = rtcm_pkg::quad_t'(phase[rtcm_pkg::PHASE_BITS-1 -: 2]);
    push_item.idx         = phase[rtcm_pkg::PHASE_BITS-3 -: rtcm_pkg::TABLE_ADDR_BITS];
    push_item.phase_after = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      start_phase <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rtcm_pkg::cfg_reg_t'(cfg_index))
        rtcm_pkg::REG_PHASE_STEP:  phase_step  <= rtcm_pkg::PHASE_BITS'(cfg_data);
        rtcm_pkg::REG_START_PHASE: start_phase <= rtcm_pkg::PHASE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // A last item makes the next one start again from start_phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      vector_start <= 1'b1;
    end else if (push) begin
      phase_acc    <= phase_next;
      vector_start <= last;
    end
  end

endmodule

### rtl/rtcm_queue.sv
// ----------------------------------------------------------------------------
// rtcm_queue: short item queue between front and back
// Small register FIFO; lets the front keep accepting while the back stalls.
// ----------------------------------------------------------------------------
module rtcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtcm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rtcm_pkg::item_t head
);

  rtcm_pkg::item_t                        entries [rtcm_pkg::QUEUE_DEPTH];
  logic [rtcm_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr;
  logic [rtcm_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr;
  logic [rtcm_pkg::QUEUE_PTR_BITS:0]      count;

  assign full       = (count == (rtcm_pkg::QUEUE_PTR_BITS+1)'(rtcm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/rtcm_back.sv
// ----------------------------------------------------------------------------
// rtcm_back: sine/cosine lookup, mixing multiply and output register
// Three stages under one enable: table read, quadrant fold and multiply,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module rtcm_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    head_valid,
  input  rtcm_pkg::item_t                         head,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_real,
  output logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_imag,
  output logic [rtcm_pkg::PHASE_BITS-1:0]         phase_after,
  output logic                                    out_last
);

  localparam rtcm_pkg::qsin_rom_t QSIN = rtcm_pkg::build_qsin();

  logic                                    advance;
  logic [rtcm_pkg::ROM_ADDR_BITS-1:0]      addr_sin;
  logic [rtcm_pkg::ROM_ADDR_BITS-1:0]      addr_cos;

  // stage 1: table read
  logic                                    v1;
  logic [rtcm_pkg::QSIN_BITS-1:0]          mag_a;
  logic [rtcm_pkg::QSIN_BITS-1:0]          mag_b;
  rtcm_pkg::quad_t                         quad1;
  logic signed [rtcm_pkg::SAMPLE_BITS-1:0] sample1;
  logic                                    last1;
  logic [rtcm_pkg::PHASE_BITS-1:0]         after1;

  // stage 2: products
  logic                                    v2;
  logic signed [rtcm_pkg::TRIG_BITS-1:0]   pos_a;
  logic signed [rtcm_pkg::TRIG_BITS-1:0]   pos_b;
  logic signed [rtcm_pkg::TRIG_BITS-1:0]   cos_v;
  logic signed [rtcm_pkg::TRIG_BITS-1:0]   sin_v;
  logic signed [rtcm_pkg::PROD_BITS-1:0]   prod_re;
  logic signed [rtcm_pkg::PROD_BITS-1:0]   prod_im;
  logic                                    last2;
  logic [rtcm_pkg::PHASE_BITS-1:0]         after2;

  // hold everything while a finished result is stalled at the output
  assign advance = !(out_valid && out_stall);
  assign pop     = advance && head_valid;

  assign addr_sin = {1'b0, head.idx};
  assign addr_cos = (rtcm_pkg::ROM_ADDR_BITS)'(rtcm_pkg::QUARTER_N) - addr_sin;

  always_ff @(posedge clk) begin
    if (pop) begin
      mag_a   <= QSIN[addr_sin];
      mag_b   <= QSIN[addr_cos];
      quad1   <= head.quad;
      sample1 <= head.sample;
      last1   <= head.last;
      after1  <= head.phase_after;
    end
  end

  assign pos_a = $signed({1'b0, mag_a});
  assign pos_b = $signed({1'b0, mag_b});

  always_comb begin
    case (quad1)
      rtcm_pkg::QUAD_I: begin
        sin_v = pos_a;
        cos_v = pos_b;
      end
      rtcm_pkg::QUAD_II: begin
        sin_v = pos_b;
        cos_v = -pos_a;
      end
      rtcm_pkg::QUAD_III: begin
        sin_v = -pos_a;
        cos_v = -pos_b;
      end
      rtcm_pkg::QUAD_IV: begin
        sin_v = -pos_b;
        cos_v = pos_a;
      end
      default: begin
        sin_v = pos_a;
        cos_v = pos_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance && v1) begin
      prod_re <= sample1 * cos_v;
      prod_im <= sample1 * sin_v;
      last2   <= last1;
      after2  <= after1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v2) begin
      out_real    <= rtcm_pkg::round_sat(prod_re);
      out_imag    <= rtcm_pkg::round_sat(prod_im);
      phase_after <= after2;
      out_last    <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= pop;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

### rtl/real_to_complex_mixer.sv
// Path: queue, then table-read, product and output registers, to out_valid.
// Throughput: one item per cycle without output stall; phase add in the front
//   and two-port sine table read in the back each take one item a cycle.
// A 4-entry queue plus 3 back stages hold up to 7 items under output stall.
// Reset (rst, synchronous): registers, phase accumulator and queue cleared;
//   the first item after reset starts a vector at start_phase.
// ----------------------------------------------------------------------------
// real_to_complex_mixer: NCO complex mixer for a real sample stream
// Multiplies each real sample by cos and sin of a running phase and
// returns the rounded complex product with the stepped phase.
// ----------------------------------------------------------------------------
module real_to_complex_mixer (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rtcm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [rtcm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [rtcm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                    last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_real,
  output logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_imag,
  output logic [rtcm_pkg::PHASE_BITS-1:0]         phase_after,
  output logic                                    out_last
);

  logic            q_full;
  logic            push;
  logic            pop;
  logic            head_valid;
  rtcm_pkg::item_t push_item;
  rtcm_pkg::item_t head;

  rtcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .last      (last),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rtcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rtcm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_real    (out_real),
    .out_imag    (out_imag),
    .phase_after (phase_after),
    .out_last    (out_last)
  );

endmodule

### rtl/rtcm_checker.sv
// ----------------------------------------------------------------------------
// rtcm_checker: port-level checks for the NCO complex mixer
// Tracks items in flight and the phase step, and checks output hold under
// stall, no output without accepted input, and phase continuity in a vector.
// ----------------------------------------------------------------------------
module rtcm_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    cfg_valid,
  input logic                                    cfg_ready,
  input logic [rtcm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input logic [rtcm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_real,
  input logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_imag,
  input logic [rtcm_pkg::PHASE_BITS-1:0]         phase_after,
  input logic                                    out_last
);

  logic                            in_fire;
  logic                            out_fire;
  logic [3:0]                      pending;
  logic [rtcm_pkg::PHASE_BITS-1:0] step;
  logic [rtcm_pkg::PHASE_BITS-1:0] prev_after;
  logic                            in_vector;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      step       <= '0;
      prev_after <= '0;
      in_vector  <= 1'b0;
    end else begin
      pending <= pending + {3'b000, in_fire} - {3'b000, out_fire};
      if (cfg_valid && cfg_ready
          && rtcm_pkg::cfg_reg_t'(cfg_index) == rtcm_pkg::REG_PHASE_STEP) begin
        step <= rtcm_pkg::PHASE_BITS'(cfg_data);
      end
      if (out_fire) begin
        prev_after <= phase_after;
        in_vector  <= !out_last;
      end
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_real) && $stable(out_imag)
      && $stable(phase_after) && $stable(out_last))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("output item without an accepted input item");

  // inside a vector the phase advances by exactly one step per item
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && in_vector |-> phase_after == prev_after + step)
    else $error("phase did not advance by the phase step");

endmodule

bind real_to_complex_mixer rtcm_checker u_rtcm_checker (.*);

### verif/real_to_complex_mixer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// real_to_complex_mixer_tb: self-checking bench for the NCO complex mixer
// Drives real samples in vectors under several phase settings, predicts
// each complex result from a local quarter-wave sine table and phase
// accumulator, and compares every output item with its prediction.
// ----------------------------------------------------------------------------
module real_to_complex_mixer_tb;

  localparam int    TIMEOUT_NS   = 5_000_000;
  localparam int    SETTLE_CYC   = 8;
  localparam int    MAX_REPORTS  = 10;
  localparam longint SMAX        = (longint'(1) << (rtcm_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN        = -SMAX - 1;

  // indexes the block has no register behind
  localparam logic [rtcm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [rtcm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [rtcm_pkg::SAMPLE_BITS-1:0] re;
    logic signed [rtcm_pkg::SAMPLE_BITS-1:0] im;
    logic [rtcm_pkg::PHASE_BITS-1:0]         ph;
    logic                                    lst;
  } mix_out_t;

  logic                                    clk;
  logic                                    rst;
  logic                                    cfg_valid;
  logic                                    cfg_ready;
  logic [rtcm_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
  logic [rtcm_pkg::CFG_DATA_BITS-1:0]      cfg_data;
  logic                                    in_valid;
  logic                                    in_stall;
  logic signed [rtcm_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    last;
  logic                                    out_valid;
  logic                                    out_stall;
  logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_real;
  logic signed [rtcm_pkg::SAMPLE_BITS-1:0] out_imag;
  logic [rtcm_pkg::PHASE_BITS-1:0]         phase_after;
  logic                                    out_last;

  // predictor state
  logic [rtcm_pkg::QSIN_BITS-1:0]  sine_q15 [0:rtcm_pkg::QUARTER_N];
  logic [rtcm_pkg::PHASE_BITS-1:0] step_reg;
  logic [rtcm_pkg::PHASE_BITS-1:0] start_reg;
  logic [rtcm_pkg::PHASE_BITS-1:0] acc_phase;
  logic                            at_vector_start;
  mix_out_t                        pending_mixes [$];

  int  err_count;
  int  n_samples;
  int  n_vectors;
  int  n_results;
  int  n_writes;
  int  hold_left;
  bit  idle_on;

  real_to_complex_mixer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_real    (out_real),
    .out_imag    (out_imag),
    .phase_after (phase_after),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sin(pi/2 * j / QUARTER_N) in Q15: odd Taylor terms to x^9, all in Q30
  function automatic logic [rtcm_pkg::QSIN_BITS-1:0] taylor_sine(int unsigned j);
    longint unsigned pw [0:4];
    longint unsigned coef [0:4];
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    coef = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172271};
    pw[0] = longint'(j) << (30 - rtcm_pkg::TABLE_ADDR_BITS);
    x2 = (pw[0] * pw[0]) >> 30;
    for (int k = 1; k < 5; k++) begin
      pw[k] = (pw[k-1] * x2) >> 30;
    end
    acc = 0;
    for (int k = 0; k < 5; k++) begin
      term = (coef[k] * pw[k]) >> 30;
      acc = (k % 2 == 0) ? acc + longint'(term) : acc - longint'(term);
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> rtcm_pkg::FRAC_BITS;
    if (acc > 32767) begin
      acc = 32767;
    end
    return acc[rtcm_pkg::QSIN_BITS-1:0];
  endfunction

  function automatic logic signed [rtcm_pkg::SAMPLE_BITS-1:0] q15_scale(
    logic signed [rtcm_pkg::SAMPLE_BITS-1:0] x, int t);
    longint p;
    p = (longint'(x) * t + 16384) >>> rtcm_pkg::FRAC_BITS;
    if (p > SMAX) begin
      p = SMAX;
    end
    if (p < SMIN) begin
      p = SMIN;
    end
    return p[rtcm_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Mix one sample and advance the phase accumulator
  function automatic mix_out_t nco_mix_next(
    logic signed [rtcm_pkg::SAMPLE_BITS-1:0] x, logic lst);
    logic [rtcm_pkg::PHASE_BITS-1:0]      ph;
    logic [rtcm_pkg::TABLE_ADDR_BITS-1:0] k;
    int                                   a;
    int                                   b;
    int                                   c;
    int                                   s;
    mix_out_t                             r;
    ph = at_vector_start ? start_reg : acc_phase;
    k  = ph[rtcm_pkg::PHASE_BITS-3 -: rtcm_pkg::TABLE_ADDR_BITS];
    a  = sine_q15[k];
    b  = sine_q15[rtcm_pkg::QUARTER_N - k];
    case (rtcm_pkg::quad_t'(ph[rtcm_pkg::PHASE_BITS-1 -: 2]))
      rtcm_pkg::QUAD_I: begin
        s = a;  c = b;
      end
      rtcm_pkg::QUAD_II: begin
        s = b;  c = -a;
      end
      rtcm_pkg::QUAD_III: begin
        s = -a; c = -b;
      end
      default: begin
        s = -b; c = a;
      end
    endcase
    r.re  = q15_scale(x, c);
    r.im  = q15_scale(x, s);
    r.ph  = ph + step_reg;
    r.lst = lst;
    acc_phase       = r.ph;
    at_vector_start = lst;
    return r;
  endfunction

  // Track register writes, predict accepted items, check output items
  always @(posedge clk) begin
    mix_out_t want;
    mix_out_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          rtcm_pkg::REG_PHASE_STEP:  step_reg  = cfg_data;
          rtcm_pkg::REG_START_PHASE: start_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_mixes.push_back(nco_mix_next(sample, last));
        n_samples++;
        if (last) begin
          n_vectors++;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_real, out_imag, phase_after, out_last};
        n_results++;
        if (pending_mixes.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected item re=%0d im=%0d ph=%h last=%0b",
                     $realtime, got.re, got.im, got.ph, got.lst);
          end
        end else begin
          want = pending_mixes.pop_front();
          if ((got.re != want.re) || (got.im != want.im) ||
              (got.ph != want.ph) || (got.lst != want.lst)) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: mismatch exp re=%0d im=%0d ph=%h last=%0b",
                       $realtime, want.re, want.im, want.ph, want.lst);
              $display("%0t:          got re=%0d im=%0d ph=%h last=%0b",
                       $realtime, got.re, got.im, got.ph, got.lst);
            end
          end
        end
      end
    end
  end

  // Receiver: long holds on request, else short random stall bursts if idle_on
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("real_to_complex_mixer_tb: FAIL");
    $finish;
  end

  task automatic send_item(logic signed [rtcm_pkg::SAMPLE_BITS-1:0] x, logic lst);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= x;
    last     <= lst;
    do @(posedge clk); while (in_stall);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic cfg_write(logic [rtcm_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [rtcm_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let every expected item come out, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [rtcm_pkg::PHASE_BITS-1:0] pick_phase_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return rtcm_pkg::PHASE_BITS'($urandom_range(1, 4096)) << 20;
      3:       return -(rtcm_pkg::PHASE_BITS'($urandom_range(1, 4096)) << 18);
      default: return rtcm_pkg::PHASE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [rtcm_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMIN[rtcm_pkg::SAMPLE_BITS-1:0];
      1:       return SMAX[rtcm_pkg::SAMPLE_BITS-1:0];
      2:       return rtcm_pkg::SAMPLE_BITS'(int'($urandom_range(0, 4)) - 2);
      default: return rtcm_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Reset values: zero step, zero start, extremes of the sample range
  task automatic test_reset_state();
    send_item(SMAX[rtcm_pkg::SAMPLE_BITS-1:0], 1'b0);
    send_item(SMIN[rtcm_pkg::SAMPLE_BITS-1:0], 1'b0);
    send_item('0, 1'b1);
  endtask

  // Quarter-turn steps through all quadrants at both table ends, wrap,
  // ignored register indexes, single-sample vectors
  task automatic test_phase_corners();
    drain();
    cfg_write(rtcm_pkg::REG_PHASE_STEP, 32'h4000_0000);
    cfg_write(rtcm_pkg::REG_START_PHASE, 32'h3FF0_0000);
    send_item(SMAX[rtcm_pkg::SAMPLE_BITS-1:0], 1'b0);
    send_item(SMIN[rtcm_pkg::SAMPLE_BITS-1:0], 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd1, 1'b1);
    drain();
    cfg_write(rtcm_pkg::REG_START_PHASE, '0);
    for (int k = 0; k < 4; k++) begin
      send_item(SMIN[rtcm_pkg::SAMPLE_BITS-1:0], k == 3);
    end
    drain();
    cfg_write(REG_SPARE_2, 32'hDEAD_BEEF);
    cfg_write(REG_SPARE_3, 32'h1234_5678);
    send_item(16'sh5A5A, 1'b0);
    send_item(16'shA5A5, 1'b1);
    drain();
    cfg_write(rtcm_pkg::REG_PHASE_STEP, '1);
    cfg_write(rtcm_pkg::REG_START_PHASE, '1);
    send_item(SMAX[rtcm_pkg::SAMPLE_BITS-1:0], 1'b0);
    send_item(SMIN[rtcm_pkg::SAMPLE_BITS-1:0], 1'b0);
    send_item(SMAX[rtcm_pkg::SAMPLE_BITS-1:0], 1'b1);
    send_item(16'sh7FFE, 1'b1);
    send_item(16'sh8001, 1'b1);
    drain();
    cfg_write(rtcm_pkg::REG_PHASE_STEP, '0);
    cfg_write(rtcm_pkg::REG_START_PHASE, 32'h8000_0000);
    send_item(16'sh4000, 1'b0);
    send_item(16'shC000, 1'b1);
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_back_pressure();
    drain();
    cfg_write(rtcm_pkg::REG_PHASE_STEP, rtcm_pkg::PHASE_BITS'($urandom));
    cfg_write(rtcm_pkg::REG_START_PHASE, rtcm_pkg::PHASE_BITS'($urandom));
    idle_on   = 1'b0;
    hold_left = 60;
    for (int k = 0; k < 32; k++) begin
      send_item(pick_sample(), (k % 11) == 10 || k == 31);
    end
  endtask

  // Vectors of random length and content under a fresh setting per phase
  task automatic test_random_vectors(int n_phases, int per_phase);
    int vec_len;
    int pos;
    for (int p = 0; p < n_phases; p++) begin
      drain();
      case (p)
        0: begin
          cfg_write(rtcm_pkg::REG_PHASE_STEP, '0);
          cfg_write(rtcm_pkg::REG_START_PHASE, '1);
        end
        1: begin
          cfg_write(rtcm_pkg::REG_PHASE_STEP, '1);
          cfg_write(rtcm_pkg::REG_START_PHASE, '0);
        end
        default: begin
          cfg_write(rtcm_pkg::REG_PHASE_STEP, pick_phase_word());
          cfg_write(rtcm_pkg::REG_START_PHASE, pick_phase_word());
        end
      endcase
      // no idling in the closing phase
      idle_on = (p != n_phases - 1) && ($urandom_range(0, 3) != 0);
      pos = 0;
      vec_len = 1;
      for (int k = 0; k < per_phase; k++) begin
        if (pos == 0) begin
          vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
        end
        if (pos == vec_len - 1 || k == per_phase - 1) begin
          send_item(pick_sample(), 1'b1);
          pos = 0;
        end else begin
          send_item(pick_sample(), 1'b0);
          pos++;
        end
      end
    end
  endtask

  initial begin
    for (int j = 0; j <= rtcm_pkg::QUARTER_N; j++) begin
      sine_q15[j] = taylor_sine(j);
    end
    step_reg        = '0;
    start_reg       = '0;
    acc_phase       = '0;
    at_vector_start = 1'b1;
    err_count = 0;
    n_samples = 0;
    n_vectors = 0;
    n_results = 0;
    n_writes  = 0;
    hold_left = 0;
    idle_on   = 1'b1;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = rtcm_pkg::REG_PHASE_STEP;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample    = '0;
    last      = 1'b0;
    out_stall = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_phase_corners();
    test_back_pressure();
    test_random_vectors(8, 235);
    drain();

    if (pending_mixes.size() != 0) begin
      err_count++;
    end
    $display("covered %0d samples in %0d vectors over %0d register writes",
             n_samples, n_vectors, n_writes);
    $display("checked %0d complex items, %0d failures", n_results, err_count);
    if (err_count == 0) begin
      $display("real_to_complex_mixer_tb: PASS");
    end else begin
      $display("real_to_complex_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/rtcm_pkg.sv
rtl/rtcm_front.sv
rtl/rtcm_queue.sv
rtl/rtcm_back.sv
rtl/real_to_complex_mixer.sv
rtl/rtcm_checker.sv
verif/real_to_complex_mixer_tb.sv
